// ===== sv/nmea_pkg.sv =====
// Package for the NMEA sentence deframer: character codes, phase and status
// codes, and the result item type.
// No dependencies.
package nmea_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [7:0] COMMA_POS   = 8'd6;
  localparam logic [7:0] MAX_LEN_RST = 8'd82;
  localparam int unsigned CNT_OUT_W  = 16;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HEX     = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_CKSUM  = 3'd1,
    ST_HEADER = 3'd2,
    ST_FIELD  = 3'd3,
    ST_LONG   = 3'd4
  } status_e;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           data_byte;
    status_e              status;
    logic                 bang_start;
    logic                 cksum_seen;
    logic [7:0]           cksum_calc;
    logic [7:0]           cksum_rcvd;
    logic [7:0]           sentence_length;
    logic [CNT_OUT_W-1:0] ok_count;
    logic [CNT_OUT_W-1:0] format_error_count;
    logic [CNT_OUT_W-1:0] checksum_error_count;
    logic [CNT_OUT_W-1:0] overflow_count;
  } result_t;

endpackage

// ===== sv/nmea_sentence_deframer.sv =====
// NMEA 0183 sentence deframer with XOR checksum check and error counters.
// Depends on nmea_pkg.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  rx_byte_i
// out      output     out_valid_o / out_stall_i kind_o .. overflow_count_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (max_sentence_len)
//
// One byte is taken in every cycle while in_stall_o is low; its result, if any, is
// registered into the result register, or into the skid register when that one holds an untaken item.
// A two-entry output buffer (result register plus skid register) sets the
// stall: in_stall_o rises only while both entries hold an item.
// Reset clears the phase, the sentence state and the counters, and sets the
// maximum length to 82. The configuration port is always ready.
module nmea_sentence_deframer #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  status_o,
  output logic        bang_start_o,
  output logic        cksum_seen_o,
  output logic [7:0]  cksum_calc_o,
  output logic [7:0]  cksum_rcvd_o,
  output logic [7:0]  sentence_length_o,
  output logic [15:0] ok_count_o,
  output logic [15:0] format_error_count_o,
  output logic [15:0] checksum_error_count_o,
  output logic [15:0] overflow_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  logic [7:0]               max_len_q;
  nmea_pkg::phase_e         phase_q, phase_d;
  logic [7:0]               pos_q, pos_d;
  logic [7:0]               xor_q, xor_d;
  logic [7:0]               hex_q, hex_d;
  logic [1:0]               hcnt_q, hcnt_d;
  logic                     hbad_q, hbad_d;
  logic                     bang_q, bang_d;
  logic [COUNTER_WIDTH-1:0] ok_q, ok_d, fmt_q, fmt_d, chk_q, chk_d, ovf_q, ovf_d;
  logic [COUNTER_WIDTH-1:0] cnt_sum;

  nmea_pkg::result_t        main_q, skid_q, res;
  logic                     main_v_q, skid_v_q;

  logic                     in_acc, pop, push, fin, do_begin;
  logic                     term, startc, too_long;
  logic [4:0]               hexd;
  nmea_pkg::status_e        st;

  assign in_acc = in_valid_i && !skid_v_q;
  assign pop    = main_v_q && !out_stall_i;
  assign term   = (rx_byte_i == nmea_pkg::CH_CR) || (rx_byte_i == nmea_pkg::CH_LF);
  assign startc = (rx_byte_i == nmea_pkg::CH_DOLLAR) || (rx_byte_i == nmea_pkg::CH_BANG);
  assign too_long = ({1'b0, pos_q} + 9'd1) > {1'b0, max_len_q};
  assign hexd   = hex_decode(rx_byte_i);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    hex_d    = hex_q;
    hcnt_d   = hcnt_q;
    hbad_d   = hbad_q;
    bang_d   = bang_q;
    ok_d     = ok_q;
    fmt_d    = fmt_q;
    chk_d    = chk_q;
    ovf_d    = ovf_q;
    push     = 1'b0;
    fin      = 1'b0;
    do_begin = 1'b0;
    st       = nmea_pkg::ST_OK;

    unique case (phase_q)
      nmea_pkg::PH_HUNT: begin
        do_begin = startc;
      end
      nmea_pkg::PH_HEADER: begin
        priority if (startc) begin
          fin      = 1'b1;
          st       = nmea_pkg::ST_HEADER;
          do_begin = 1'b1;
        end else if (term) begin
          fin = 1'b1;
          st  = nmea_pkg::ST_HEADER;
        end else if (too_long) begin
          fin = 1'b1;
          st  = nmea_pkg::ST_LONG;
        end else if (pos_q >= nmea_pkg::COMMA_POS && rx_byte_i != nmea_pkg::CH_COMMA) begin
          fin = 1'b1;
          st  = nmea_pkg::ST_HEADER;
        end else begin
          if (pos_q >= nmea_pkg::COMMA_POS) begin
            phase_d = nmea_pkg::PH_PAYLOAD;
          end
          pos_d = pos_q + 8'd1;
          xor_d = xor_q ^ rx_byte_i;
          push  = 1'b1;
        end
      end
      nmea_pkg::PH_PAYLOAD: begin
        priority if (term) begin
          fin = 1'b1;
          st  = nmea_pkg::ST_OK;
        end else if (too_long) begin
          fin = 1'b1;
          st  = nmea_pkg::ST_LONG;
        end else begin
          pos_d = pos_q + 8'd1;
          if (rx_byte_i == nmea_pkg::CH_STAR) begin
            phase_d = nmea_pkg::PH_HEX;
            hex_d   = '0;
            hcnt_d  = '0;
            hbad_d  = 1'b0;
          end else begin
            xor_d = xor_q ^ rx_byte_i;
            push  = 1'b1;
          end
        end
      end
      nmea_pkg::PH_HEX: begin
        priority if (term) begin
          fin = 1'b1;
          if (hbad_q || hcnt_q != 2'd2) begin
            st = nmea_pkg::ST_FIELD;
          end else if (hex_q == xor_q) begin
            st = nmea_pkg::ST_OK;
          end else begin
            st = nmea_pkg::ST_CKSUM;
          end
        end else if (too_long) begin
          fin = 1'b1;
          st  = nmea_pkg::ST_LONG;
        end else begin
          pos_d = pos_q + 8'd1;
          if (!hexd[4] || hcnt_q >= 2'd2) begin
            hbad_d = 1'b1;
          end else begin
            hex_d = {hex_q[3:0], hexd[3:0]};
          end
          if (hcnt_q != 2'd3) begin
            hcnt_d = hcnt_q + 2'd1;
          end
        end
      end
    endcase

    if (fin) begin
      push    = 1'b1;
      phase_d = nmea_pkg::PH_HUNT;
      unique case (st)
        nmea_pkg::ST_OK:    ok_d  = ok_q + COUNTER_WIDTH'(1);
        nmea_pkg::ST_CKSUM: chk_d = chk_q + COUNTER_WIDTH'(1);
        nmea_pkg::ST_LONG:  ovf_d = ovf_q + COUNTER_WIDTH'(1);
        default:            fmt_d = fmt_q + COUNTER_WIDTH'(1);
      endcase
    end

    if (do_begin) begin
      phase_d = nmea_pkg::PH_HEADER;
      pos_d   = 8'd1;
      xor_d   = '0;
      hex_d   = '0;
      hcnt_d  = '0;
      hbad_d  = 1'b0;
      bang_d  = (rx_byte_i == nmea_pkg::CH_BANG);
    end

    res.kind                 = fin;
    res.data_byte            = fin ? 8'd0 : rx_byte_i;
    res.status               = st;
    res.bang_start           = bang_q;
    res.cksum_seen           = fin && (phase_q == nmea_pkg::PH_HEX);
    res.cksum_calc           = fin ? xor_q : xor_d;
    res.cksum_rcvd           = (fin && phase_q == nmea_pkg::PH_HEX) ? hex_q : 8'd0;
    res.sentence_length      = fin ? pos_q : pos_d;
    res.ok_count             = nmea_pkg::CNT_OUT_W'(ok_d);
    res.format_error_count   = nmea_pkg::CNT_OUT_W'(fmt_d);
    res.checksum_error_count = nmea_pkg::CNT_OUT_W'(chk_d);
    res.overflow_count       = nmea_pkg::CNT_OUT_W'(ovf_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= nmea_pkg::MAX_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nmea_pkg::PH_HUNT;
      pos_q   <= '0;
      xor_q   <= '0;
      hex_q   <= '0;
      hcnt_q  <= '0;
      hbad_q  <= 1'b0;
      bang_q  <= 1'b0;
      ok_q    <= '0;
      fmt_q   <= '0;
      chk_q   <= '0;
      ovf_q   <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
      hex_q   <= hex_d;
      hcnt_q  <= hcnt_d;
      hbad_q  <= hbad_d;
      bang_q  <= bang_d;
      ok_q    <= ok_d;
      fmt_q   <= fmt_d;
      chk_q   <= chk_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        main_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (in_acc && push) begin
      if (!main_v_q || pop) begin
        main_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (in_acc && push) begin
      if (!main_v_q || pop) begin
        main_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign in_stall_o             = skid_v_q;
  assign cfg_ready_o            = 1'b1;
  assign out_valid_o            = main_v_q;
  assign kind_o                 = main_q.kind;
  assign data_byte_o            = main_q.data_byte;
  assign status_o               = main_q.status;
  assign bang_start_o           = main_q.bang_start;
  assign cksum_seen_o           = main_q.cksum_seen;
  assign cksum_calc_o           = main_q.cksum_calc;
  assign cksum_rcvd_o           = main_q.cksum_rcvd;
  assign sentence_length_o      = main_q.sentence_length;
  assign ok_count_o             = main_q.ok_count;
  assign format_error_count_o   = main_q.format_error_count;
  assign checksum_error_count_o = main_q.checksum_error_count;
  assign overflow_count_o       = main_q.overflow_count;

  assign cnt_sum = ok_q + fmt_q + chk_q + ovf_q;

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held while result register empty");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fin) |=> cnt_sum == COUNTER_WIDTH'($past(cnt_sum) + COUNTER_WIDTH'(1)))
    else $error("status item did not advance exactly one counter");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && fin) |=> $stable(cnt_sum))
    else $error("counters changed without a status item");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_v_q && !main_q.kind) |->
      (main_q.status == nmea_pkg::ST_OK && !main_q.cksum_seen))
    else $error("payload item carries status fields");

  a_pos_in_sentence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != nmea_pkg::PH_HUNT) |-> (pos_q != 8'd0))
    else $error("byte position zero inside a sentence");

endmodule

// ===== verif/nmea_sentence_deframer_tb.sv =====
// Self-checking testbench for the NMEA sentence deframer: directed frames, a long
// receiver hold-off, length limits and random sentence traffic, checked per item.
// Depends on nmea_pkg and nmea_sentence_deframer.
`timescale 1ns / 100ps

module nmea_sentence_deframer_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 120;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [7:0]  cfg_data_i  = 8'h00;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  status_o;
  logic        bang_start_o;
  logic        cksum_seen_o;
  logic [7:0]  cksum_calc_o;
  logic [7:0]  cksum_rcvd_o;
  logic [7:0]  sentence_length_o;
  logic [15:0] ok_count_o;
  logic [15:0] format_error_count_o;
  logic [15:0] checksum_error_count_o;
  logic [15:0] overflow_count_o;
  logic        cfg_ready_o;

  nmea_sentence_deframer u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sentence state mirrored from the received bytes.
  nmea_pkg::phase_e sen_phase = nmea_pkg::PH_HUNT;
  logic [7:0]  sen_len        = 8'd0;
  logic [7:0]  sen_xor        = 8'd0;
  logic [7:0]  sen_hex        = 8'd0;
  logic [1:0]  sen_hex_digits = 2'd0;
  logic        sen_hex_bad    = 1'b0;
  logic        sen_bang       = 1'b0;
  logic [7:0]  cfg_max_len    = nmea_pkg::MAX_LEN_RST;
  logic [15:0] ok_total       = 16'd0;
  logic [15:0] format_total   = 16'd0;
  logic [15:0] cksum_total    = 16'd0;
  logic [15:0] long_total     = 16'd0;

  nmea_pkg::result_t expected_items[$];
  int      mismatches    = 0;
  int      bytes_sent    = 0;
  int      burst_left    = 0;
  int      hold_requests = 0;
  int      holds_served  = 0;
  int      hold_left     = 0;
  int      stall_pct     = 0;
  int      mode_left     = 0;
  int      quiet_cycles  = 0;

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic nmea_pkg::result_t pack_item(logic kind, logic [7:0] data,
                                                  nmea_pkg::status_e st);
    nmea_pkg::result_t r;
    logic              has_cks;
    has_cks             = kind && (sen_phase == nmea_pkg::PH_HEX);
    r.kind              = kind;
    r.data_byte         = data;
    r.status            = st;
    r.bang_start        = sen_bang;
    r.cksum_seen        = has_cks;
    r.cksum_calc        = sen_xor;
    r.cksum_rcvd        = has_cks ? sen_hex : 8'd0;
    r.sentence_length   = sen_len;
    r.ok_count             = ok_total;
    r.format_error_count   = format_total;
    r.checksum_error_count = cksum_total;
    r.overflow_count       = long_total;
    return r;
  endfunction

  task automatic open_sentence(logic [7:0] b);
    sen_phase      = nmea_pkg::PH_HEADER;
    sen_len        = 8'd1;
    sen_xor        = 8'd0;
    sen_hex        = 8'd0;
    sen_hex_digits = 2'd0;
    sen_hex_bad    = 1'b0;
    sen_bang       = (b == nmea_pkg::CH_BANG);
  endtask

  task automatic close_sentence(nmea_pkg::status_e st);
    case (st)
      nmea_pkg::ST_OK:    ok_total++;
      nmea_pkg::ST_CKSUM: cksum_total++;
      nmea_pkg::ST_LONG:  long_total++;
      default:            format_total++;
    endcase
    expected_items.push_back(pack_item(1'b1, 8'd0, st));
    sen_phase = nmea_pkg::PH_HUNT;
  endtask

  task automatic deframe_byte(logic [7:0] b);
    logic term;
    logic startc;
    int   d;
    term   = (b == nmea_pkg::CH_CR) || (b == nmea_pkg::CH_LF);
    startc = (b == nmea_pkg::CH_DOLLAR) || (b == nmea_pkg::CH_BANG);
    if (sen_phase == nmea_pkg::PH_HUNT) begin
      if (startc) open_sentence(b);
    end else if (sen_phase == nmea_pkg::PH_HEADER && startc) begin
      close_sentence(nmea_pkg::ST_HEADER);
      open_sentence(b);
    end else if (term) begin
      if (sen_phase == nmea_pkg::PH_HEADER) close_sentence(nmea_pkg::ST_HEADER);
      else if (sen_phase == nmea_pkg::PH_PAYLOAD) close_sentence(nmea_pkg::ST_OK);
      else if (sen_hex_bad || sen_hex_digits != 2'd2) close_sentence(nmea_pkg::ST_FIELD);
      else if (sen_hex == sen_xor) close_sentence(nmea_pkg::ST_OK);
      else close_sentence(nmea_pkg::ST_CKSUM);
    end else if ({1'b0, sen_len} + 9'd1 > {1'b0, cfg_max_len}) begin
      close_sentence(nmea_pkg::ST_LONG);
    end else if (sen_phase == nmea_pkg::PH_HEADER && sen_len >= nmea_pkg::COMMA_POS &&
                 b != nmea_pkg::CH_COMMA) begin
      close_sentence(nmea_pkg::ST_HEADER);
    end else if (sen_phase == nmea_pkg::PH_HEX) begin
      sen_len++;
      d = hex_nibble(b);
      if (d < 0 || sen_hex_digits >= 2'd2) sen_hex_bad = 1'b1;
      else sen_hex = {sen_hex[3:0], 4'(d)};
      if (sen_hex_digits < 2'd3) sen_hex_digits++;
    end else if (sen_phase == nmea_pkg::PH_PAYLOAD && b == nmea_pkg::CH_STAR) begin
      sen_len++;
      sen_phase      = nmea_pkg::PH_HEX;
      sen_hex        = 8'd0;
      sen_hex_digits = 2'd0;
      sen_hex_bad    = 1'b0;
    end else begin
      if (sen_phase == nmea_pkg::PH_HEADER && sen_len >= nmea_pkg::COMMA_POS) begin
        sen_phase = nmea_pkg::PH_PAYLOAD;
      end
      sen_len++;
      sen_xor ^= b;
      expected_items.push_back(pack_item(1'b0, b, nmea_pkg::ST_OK));
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] text_xor(string s);
    logic [7:0] x;
    x = 8'd0;
    for (int i = 0; i < s.len(); i++) x ^= s[i];
    return x;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == nmea_pkg::CH_CR || c == nmea_pkg::CH_LF || c == nmea_pkg::CH_STAR ||
           c == nmea_pkg::CH_DOLLAR || c == nmea_pkg::CH_BANG);
    return c;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_items.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_len(logic [7:0] len);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_max_len = len;
  endtask

  task automatic send_random_sentence();
    logic [7:0] cks;
    logic [7:0] c;
    int         pick;
    int         plen;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    cks = 8'd0;
    send_byte($urandom_range(0, 1) ? nmea_pkg::CH_BANG : nmea_pkg::CH_DOLLAR);
    for (int i = 1; i <= 6; i++) begin
      if (i == 6 && $urandom_range(0, 9) != 0) c = nmea_pkg::CH_COMMA;
      else if ($urandom_range(0, 29) == 0) c = 8'($urandom_range(0, 255));
      else c = plain_char();
      cks ^= c;
      send_byte(c);
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) plen = $urandom_range(0, 12);
    else if (pick < 95) plen = $urandom_range(0, int'(cfg_max_len));
    else plen = int'(cfg_max_len) - 9 + $urandom_range(0, 4);
    if (plen < 0) plen = 0;
    repeat (plen) begin
      if ($urandom_range(0, 19) == 0) begin
        c = $urandom_range(0, 1) ? nmea_pkg::CH_DOLLAR : nmea_pkg::CH_BANG;
      end else if ($urandom_range(0, 49) == 0) c = 8'($urandom_range(0, 255));
      else c = plain_char();
      cks ^= c;
      send_byte(c);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_text($urandom_range(0, 1) ? $sformatf("*%02X", cks) : $sformatf("*%02x", cks));
    end else if (pick < 65) begin
      send_text($sformatf("*%02X", cks ^ 8'($urandom_range(1, 255))));
    end else if (pick < 80) begin
      do c = plain_char(); while (hex_nibble(c) >= 0);
      case ($urandom_range(0, 3))
        0: send_text($sformatf("*%01X", cks[3:0]));
        1: send_text($sformatf("*%02X%01x", cks, cks[7:4]));
        2: begin
          send_byte(nmea_pkg::CH_STAR);
          send_byte(c);
          send_text($sformatf("%01X", cks[3:0]));
        end
        default: send_byte(nmea_pkg::CH_STAR);
      endcase
    end
    case ($urandom_range(0, 19))
      0:       ;
      1, 2, 3: send_text("\r\n");
      default: send_byte($urandom_range(0, 1) ? nmea_pkg::CH_CR : nmea_pkg::CH_LF);
    endcase
  endtask

  task automatic test_directed_frames();
    send_text("$GPGGA,1\r");
    send_text($sformatf("!AIVDM,A*%02X\n", text_xor("AIVDM,A")));
    send_text($sformatf("$GPGLL,z*%02x\r\n", text_xor("GPGLL,z")));
    send_text("$GPGLL,*00\r");
    send_text("$GPGLL,*G1\r$GPGLL,*1\n$GPGLL,*123\r");
    send_text("$AB!CDEFG,\n");
    send_text("$ABC\r$ABCDEX");
    send_text("$ABCDE,$!\r");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$ABCDE,");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(nmea_pkg::CH_CR);
    wait_drained();
  endtask

  task automatic test_receiver_hold();
    hold_requests++;
    @(posedge clk_i);
    burst_left = 1000000;
    send_text("$GPRMC,");
    repeat (40) send_byte(plain_char());
    send_text("\r\n");
    burst_left = 0;
    wait_drained();
  endtask

  task automatic test_length_boundary();
    write_max_len(8'd255);
    send_text("$ABCDE,");
    repeat (248) send_byte(plain_char());
    send_byte(nmea_pkg::CH_CR);
    send_text("!ABCDE,");
    repeat (249) send_byte(plain_char());
    send_byte(nmea_pkg::CH_LF);
    write_max_len(8'd8);
    send_text("$ABCDE,X\r$ABCDE,XY\r$ABCDE,*5\r");
    wait_drained();
  endtask

  task automatic test_random_traffic(logic [7:0] len, int budget);
    int first;
    first = bytes_sent;
    write_max_len(len);
    while (bytes_sent - first < budget) send_random_sentence();
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 70;
          default: stall_pct = 95;
        endcase
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    nmea_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_items.size() == 0) begin
        $display("%0t ns: result item with none expected, actual kind %0h status %0h",
                 $time, kind_o, status_o);
        mismatches++;
      end else begin
        want = expected_items.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("data_byte", want.data_byte, data_byte_o);
        check_field("status", want.status, status_o);
        check_field("bang_start", want.bang_start, bang_start_o);
        check_field("cksum_seen", want.cksum_seen, cksum_seen_o);
        check_field("cksum_calc", want.cksum_calc, cksum_calc_o);
        check_field("cksum_rcvd", want.cksum_rcvd, cksum_rcvd_o);
        check_field("sentence_length", want.sentence_length, sentence_length_o);
        check_field("ok_count", want.ok_count, ok_count_o);
        check_field("format_error_count", want.format_error_count, format_error_count_o);
        check_field("checksum_error_count", want.checksum_error_count,
                    checksum_error_count_o);
        check_field("overflow_count", want.overflow_count, overflow_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d items still expected",
               $time, WATCHDOG_LIMIT, expected_items.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_receiver_hold();
    test_length_boundary();
    test_random_traffic(8'd8, 150);
    test_random_traffic(8'd255, 150);
    test_random_traffic(8'($urandom_range(9, 254)), 120);
    test_random_traffic(nmea_pkg::MAX_LEN_RST, 220);
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d input bytes and %0d sentence ends: %0d ok, %0d checksum mismatches,",
             bytes_sent, ok_total + format_total + cksum_total + long_total, ok_total,
             cksum_total);
    $display("%0d header or field errors and %0d too long, over four maximum lengths.",
             format_total, long_total);
    if (mismatches == 0 && expected_items.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
